/* rtl/core/sip_pkg.sv */
package sip_pkg;

	// Fraction bits of the brightness scale
	localparam int GAIN_FRAC_BITS = 8;

	// Register indexes on the configuration port
	localparam logic [2:0] CFG_COMBINE_MODE = 3'd0;
	localparam logic [2:0] CFG_RED_WEIGHT   = 3'd1;
	localparam logic [2:0] CFG_GREEN_WEIGHT = 3'd2;
	localparam logic [2:0] CFG_BLUE_WEIGHT  = 3'd3;
	localparam logic [2:0] CFG_ALPHA_WEIGHT = 3'd4;
	localparam logic [2:0] CFG_BRIGHTNESS   = 3'd5;
	localparam logic [2:0] CFG_CONTRAST     = 3'd6;

	localparam logic MODE_AVG = 1'b0;
	localparam logic MODE_MAX = 1'b1;

	// floor(s / 3) == (s * 683) >> 11 for s below 1024
	localparam int DIV3_MUL   = 683;
	localparam int DIV3_SHIFT = 11;

	// Contrast curve: ((2c - 255) * gain + 255 * 256) >> 9
	localparam int CONTRAST_BIAS  = 255 * 256;
	localparam int CONTRAST_SHIFT = 9;

	typedef logic signed [23:0] term_t;
	typedef logic signed [25:0] psum_t;

	typedef struct packed {
		logic               mode;
		logic signed [15:0] w_red;
		logic signed [15:0] w_green;
		logic signed [15:0] w_blue;
		logic signed [15:0] w_alpha;
		logic [15:0]        scale;
		logic signed [15:0] gain;
	} cfg_t;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	typedef struct packed {
		psum_t      p;
		logic [2:0] n;
		logic [7:0] alpha;
	} comb_t;

	typedef struct packed {
		logic [7:0] c;
		logic [7:0] alpha;
	} inten_t;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] gray;
	} result_t;

endpackage

/* rtl/core/specular_intensity_pixel_top.sv */
// Specular intensity pixel: RGBA in, weighted gray level plus the original
// alpha out.
// Input channel s_*: one pixel per item, tdata = red, green, blue, alpha
// from the lowest byte up. Output channel m_*: tdata = gray, alpha.
// Configuration: cfg_wen/cfg_index/cfg_wdata write one register per clock;
// index 0 combine mode, 1..4 red/green/blue/alpha weights, 5 brightness
// scale, 6 contrast gain; other indexes are ignored. Write only while the
// pipeline is empty.
// Throughput: one item per clock while the output is not stalled, through six
// register stages (products, combine, brightness multiply, divide and clamp,
// contrast multiply, clamp); m_tvalid is the valid bit of the last of them.
// Each stage holds its own valid bit and stalls only when it is full and the
// stage after it cannot take its item, so bubbles close up and s_tready stays
// high while any stage has room.
// Reset empties the pipeline and loads the default registers: average mode,
// unit weights on red, green and blue, zero alpha weight, unit brightness
// and unit contrast.
module specular_intensity_pixel_top #(
	parameter int WEIGHT_FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // red_in, green_in, blue_in, alpha_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // gray_out, alpha_out
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	sip_pkg::cfg_t    cfg_q;
	sip_pkg::comb_t   comb;
	sip_pkg::inten_t  inten;
	sip_pkg::result_t res;
	logic             comb_valid;
	logic             comb_ready;
	logic             inten_valid;
	logic             inten_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode    <= sip_pkg::MODE_AVG;
			cfg_q.w_red   <= 16'sd256;
			cfg_q.w_green <= 16'sd256;
			cfg_q.w_blue  <= 16'sd256;
			cfg_q.w_alpha <= 16'sd0;
			cfg_q.scale   <= 16'd256;
			cfg_q.gain    <= 16'sd256;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				sip_pkg::CFG_COMBINE_MODE: cfg_q.mode    <= cfg_wdata[0];
				sip_pkg::CFG_RED_WEIGHT:   cfg_q.w_red   <= cfg_wdata;
				sip_pkg::CFG_GREEN_WEIGHT: cfg_q.w_green <= cfg_wdata;
				sip_pkg::CFG_BLUE_WEIGHT:  cfg_q.w_blue  <= cfg_wdata;
				sip_pkg::CFG_ALPHA_WEIGHT: cfg_q.w_alpha <= cfg_wdata;
				sip_pkg::CFG_BRIGHTNESS:   cfg_q.scale   <= cfg_wdata;
				sip_pkg::CFG_CONTRAST:     cfg_q.gain    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	sip_weigh u_weigh (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_pix    (sip_pkg::pixel_t'(s_tdata)),
		.out_valid (comb_valid),
		.out_ready (comb_ready),
		.out_data  (comb)
	);

	sip_scale #(
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (comb_valid),
		.in_ready  (comb_ready),
		.in_data   (comb),
		.out_valid (inten_valid),
		.out_ready (inten_ready),
		.out_data  (inten)
	);

	sip_contrast u_contrast (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (inten_valid),
		.in_ready  (inten_ready),
		.in_data   (inten),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res)
	);

	assign m_tdata = res;

	// an empty or draining output stage lets every stage advance
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled with output free");

	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!inten_ready |-> (m_tvalid && !m_tready))
		else $error("middle stall without output stall");

endmodule

/* rtl/core/sip_weigh.sv */
module sip_weigh (
	input  logic             clk,
	input  logic             arst_n,
	input  sip_pkg::cfg_t    cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  sip_pkg::pixel_t  in_pix,
	output logic             out_valid,
	input  logic             out_ready,
	output sip_pkg::comb_t   out_data
);

	logic               v_s1;
	sip_pkg::term_t     t_s1 [4];
	logic [2:0]         n_s1;
	logic [7:0]         alpha_s1;
	logic               v_s2;
	sip_pkg::comb_t     comb_s2;

	logic               ready_s1;
	logic               ready_s2;
	logic [7:0]         x [4];
	logic signed [15:0] w [4];
	logic signed [24:0] prod [4];
	logic [2:0]         nz;
	logic [2:0]         n_c;
	sip_pkg::psum_t     sum_c;
	sip_pkg::term_t     max_c;

	assign ready_s2 = !v_s2 || out_ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_ready = ready_s1;

	assign x[0] = in_pix.red;
	assign x[1] = in_pix.green;
	assign x[2] = in_pix.blue;
	assign x[3] = in_pix.alpha;
	assign w[0] = cfg.w_red;
	assign w[1] = cfg.w_green;
	assign w[2] = cfg.w_blue;
	assign w[3] = cfg.w_alpha;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			prod[i] = $signed({1'b0, x[i]}) * w[i];
		end
		nz = 3'($countones({w[0] != 16'sd0, w[1] != 16'sd0,
			w[2] != 16'sd0, w[3] != 16'sd0}));
		// max mode and all-zero weights both divide by one
		n_c = (cfg.mode == sip_pkg::MODE_MAX || nz == 3'd0) ? 3'd1 : nz;
	end

	always_comb begin
		sum_c = sip_pkg::psum_t'(t_s1[0]) + sip_pkg::psum_t'(t_s1[1])
			+ sip_pkg::psum_t'(t_s1[2]) + sip_pkg::psum_t'(t_s1[3]);
		max_c = t_s1[0];
		for (int i = 1; i < 4; i++) begin
			if (t_s1[i] > max_c) begin
				max_c = t_s1[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= in_valid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			for (int i = 0; i < 4; i++) begin
				t_s1[i] <= prod[i][23:0];
			end
			n_s1     <= n_c;
			alpha_s1 <= in_pix.alpha;
		end
		if (ready_s2 && v_s1) begin
			comb_s2.p     <= (cfg.mode == sip_pkg::MODE_MAX) ?
				sip_pkg::psum_t'(max_c) : sum_c;
			comb_s2.n     <= n_s1;
			comb_s2.alpha <= alpha_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = comb_s2;

	a_n_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (comb_s2.n >= 3'd1 && comb_s2.n <= 3'd4))
		else $error("divisor out of range");

endmodule

/* rtl/core/sip_scale.sv */
module sip_scale #(
	parameter int WEIGHT_FRAC_BITS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  sip_pkg::cfg_t   cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  sip_pkg::comb_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output sip_pkg::inten_t out_data
);

	localparam int SHIFT = WEIGHT_FRAC_BITS + sip_pkg::GAIN_FRAC_BITS;

	logic            v_s3;
	logic [40:0]     num_s3;
	logic [2:0]      n_s3;
	logic [7:0]      alpha_s3;
	logic            v_s4;
	sip_pkg::inten_t inten_s4;

	logic            ready_s3;
	logic            ready_s4;
	logic            pos;
	logic [40:0]     num_c;
	logic            ovf;
	logic [9:0]      s;
	logic [19:0]     s_by3;
	logic [9:0]      q;
	logic [7:0]      c_c;

	assign ready_s4 = !v_s4 || out_ready;
	assign ready_s3 = !v_s3 || ready_s4;
	assign in_ready = ready_s3;

	// negative or zero intensity clamps to zero
	assign pos   = in_data.p > sip_pkg::psum_t'(0);
	assign num_c = pos ? (in_data.p[24:0] * cfg.scale) : 41'd0;

	always_comb begin
		// beyond 1023 the quotient saturates for any divisor up to four
		ovf   = |(num_s3 >> (SHIFT + 10));
		s     = ovf ? 10'h3FF : num_s3[SHIFT +: 10];
		s_by3 = s * 10'(sip_pkg::DIV3_MUL);
		case (n_s3)
			3'd2:    q = {1'b0, s[9:1]};
			3'd3:    q = 10'(s_by3 >> sip_pkg::DIV3_SHIFT);
			3'd4:    q = {2'b00, s[9:2]};
			default: q = s;
		endcase
		c_c = (q > 10'd255) ? 8'hFF : q[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ready_s3) begin
				v_s3 <= in_valid;
			end
			if (ready_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && in_valid) begin
			num_s3   <= num_c;
			n_s3     <= in_data.n;
			alpha_s3 <= in_data.alpha;
		end
		if (ready_s4 && v_s3) begin
			inten_s4.c     <= c_c;
			inten_s4.alpha <= alpha_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = inten_s4;

	a_nonpos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !pos) |=> (num_s3 == 41'd0))
		else $error("non-positive intensity not cleared");

endmodule

/* rtl/core/sip_contrast.sv */
module sip_contrast (
	input  logic             clk,
	input  logic             arst_n,
	input  sip_pkg::cfg_t    cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  sip_pkg::inten_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output sip_pkg::result_t out_data
);

	logic               v_s5;
	logic signed [25:0] prod_s5;
	logic [7:0]         alpha_s5;
	logic               v_s6;
	sip_pkg::result_t   res_s6;

	logic               ready_s5;
	logic               ready_s6;
	logic signed [9:0]  d;
	logic signed [26:0] acc;
	logic [17:0]        qv;
	logic [7:0]         gray_c;

	assign ready_s6 = !v_s6 || out_ready;
	assign ready_s5 = !v_s5 || ready_s6;
	assign in_ready = ready_s5;

	// offset from mid gray, doubled: 2c - 255
	assign d = $signed({1'b0, in_data.c, 1'b0}) - 10'sd255;

	always_comb begin
		acc = 27'(prod_s5) + 27'(sip_pkg::CONTRAST_BIAS);
		qv  = acc[26:sip_pkg::CONTRAST_SHIFT];
		if (acc < 27'sd0) begin
			gray_c = 8'd0;
		end else if (|qv[17:8]) begin
			gray_c = 8'hFF;
		end else begin
			gray_c = qv[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (ready_s5) begin
				v_s5 <= in_valid;
			end
			if (ready_s6) begin
				v_s6 <= v_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s5 && in_valid) begin
			prod_s5  <= d * cfg.gain;
			alpha_s5 <= in_data.alpha;
		end
		if (ready_s6 && v_s5) begin
			res_s6.gray  <= gray_c;
			res_s6.alpha <= alpha_s5;
		end
	end

	assign out_valid = v_s6;
	assign out_data  = res_s6;

endmodule
